// ===== rtl/erst_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Echo tracker package
// Shared codes, word types and state encodings for the echo reply tracker.
// ----------------------------------------------------------------------------
package erst_pkg;

   // Input word type codes
   localparam logic [1:0] REQ_SEND    = 2'd0;
   localparam logic [1:0] REQ_REPLY   = 2'd1;
   localparam logic [1:0] REQ_RESTART = 2'd2;

   // Arrival classes of a result word
   localparam logic [1:0] CLASS_IN_ORDER = 2'd0;
   localparam logic [1:0] CLASS_JUMP     = 2'd1;
   localparam logic [1:0] CLASS_LATE     = 2'd2;
   localparam logic [1:0] CLASS_NONE     = 2'd3;

   // Register map
   localparam logic [1:0] CSR_MY_ID_ADDR = 2'd0;

   localparam logic [31:0] TIME_MAX = 32'hFFFF_FFFF;
   localparam logic [31:0] SEQ_MAX  = 32'hFFFF_FFFF;

   // Work kind decided by the front end
   typedef enum logic [2:0] {
      KIND_SEND,
      KIND_REPLY,
      KIND_RESTART,
      KIND_FOREIGN,
      KIND_NOP
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [31:0] now_time;
      logic [31:0] reply_seq;
   } item_type;

   typedef struct packed {
      logic [31:0]        seq_out;
      logic               accepted;
      logic               is_dup;
      logic               rtt_valid;
      logic [31:0]        rtt;
      logic [1:0]         arrival_class;
      logic signed [31:0] loss_total;
      logic [31:0]        late_total;
      logic [31:0]        reply_total;
      logic [31:0]        dup_total;
   } rsp_type;

   typedef struct packed {
      logic        seen;
      logic [31:0] stamp;
   } slot_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_REM,
      ST_LOOK,
      ST_FINISH
   } back_state_type;

endpackage

// ===== rtl/erst_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Echo tracker input channel
// Valid/ready channel carrying one event word.
// ----------------------------------------------------------------------------
interface erst_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  req_type;
   logic [31:0] now_time;
   logic [15:0] reply_id;
   logic [31:0] reply_seq;

   modport source (output valid, output req_type, output now_time, output reply_id,
                   output reply_seq, input ready);
   modport sink   (input valid, input req_type, input now_time, input reply_id,
                   input reply_seq, output ready);
endinterface

// ===== rtl/erst_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Echo tracker result channel
// Valid/ready channel carrying one result word.
// ----------------------------------------------------------------------------
interface erst_rsp_if;
   logic               valid;
   logic               ready;
   logic [31:0]        seq_out;
   logic               accepted;
   logic               is_dup;
   logic               rtt_valid;
   logic [31:0]        rtt;
   logic [1:0]         arrival_class;
   logic signed [31:0] loss_total;
   logic [31:0]        late_total;
   logic [31:0]        reply_total;
   logic [31:0]        dup_total;

   modport source (output valid, output seq_out, output accepted, output is_dup,
                   output rtt_valid, output rtt, output arrival_class,
                   output loss_total, output late_total, output reply_total,
                   output dup_total, input ready);
   modport sink   (input valid, input seq_out, input accepted, input is_dup,
                   input rtt_valid, input rtt, input arrival_class,
                   input loss_total, input late_total, input reply_total,
                   input dup_total, output ready);
endinterface

// ===== rtl/erst_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Echo tracker front end
// Accepts event words and classifies them into work kinds for the queue.
// ----------------------------------------------------------------------------
module erst_front (
   erst_req_if.sink           req,
   input  logic [15:0]        my_id,
   input  logic               fifo_full,
   input  logic               clearing,
   output logic               push,
   output erst_pkg::item_type push_item
);
   import erst_pkg::*;

   kind_type kind;

   always_comb begin
      unique case (req.req_type)
         REQ_SEND:    kind = KIND_SEND;
         REQ_RESTART: kind = KIND_RESTART;
         REQ_REPLY:   kind = (req.reply_id == my_id) ? KIND_REPLY : KIND_FOREIGN;
         default:     kind = KIND_NOP;
      endcase
   end

   assign req.ready = !fifo_full && !clearing;
   assign push      = req.valid && req.ready;

   assign push_item.kind      = kind;
   assign push_item.now_time  = req.now_time;
   assign push_item.reply_seq = req.reply_seq;

endmodule

// ===== rtl/erst_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Echo tracker work queue
// Two-entry queue between the front end and the back end.
// ----------------------------------------------------------------------------
module erst_fifo (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  erst_pkg::item_type push_item,
   output logic               full,
   input  logic               pop,
   output logic               empty,
   output erst_pkg::item_type head
);
   import erst_pkg::*;

   localparam int ENTRIES = 2;

   item_type    mem_ff [ENTRIES];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;

   assign full  = (count_ff == 2'(ENTRIES));
   assign empty = (count_ff == 2'd0);
   assign head  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== rtl/erst_rem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Echo tracker slot index unit
// Reduces a sequence number modulo the ring depth; a mask for a power of
// two, else a byte fold, a reciprocal multiply and a remainder step, each registered.
// ----------------------------------------------------------------------------
module erst_rem #(
   parameter int DIVISOR = 64
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [31:0]                  value,
   output logic                         done,
   output logic [$clog2(DIVISOR)-1:0]   rem
);
   localparam int  RW   = $clog2(DIVISOR);
   localparam bit  POW2 = ((DIVISOR & (DIVISOR - 1)) == 0);

   generate
      if (POW2) begin : g_mask
         logic          done_ff;
         logic [RW-1:0] rem_ff;

         always_ff @(posedge clock) begin
            if (reset) begin
               done_ff <= 1'b0;
            end else begin
               done_ff <= start;
            end
         end

         always_ff @(posedge clock) begin
            if (start) begin
               rem_ff <= value[RW-1:0];
            end
         end

         assign done = done_ff;
         assign rem  = rem_ff;
      end else begin : g_fold
         // Fold the four bytes with their weights modulo DIVISOR into a sum
         // below 2^20, then strip whole multiples with a reciprocal multiply.
         localparam int FW    = 20;
         localparam int SHIFT = 30;
         localparam int W1    = 256 % DIVISOR;
         localparam int W2    = 65536 % DIVISOR;
         localparam int W3    = 16777216 % DIVISOR;
         localparam int RECIP = ((1 << SHIFT) + DIVISOR - 1) / DIVISOR;

         logic                  fold_vld_ff;
         logic                  quo_vld_ff;
         logic                  done_ff;
         logic [FW-1:0]         fold_ff, fold_in;
         logic [FW-1:0]         held_ff;
         logic [FW-1:0]         quo_ff, quo_in;
         logic [RW-1:0]         rem_ff, rem_in;
         logic [FW+SHIFT-1:0]   prod;

         always_comb begin
            fold_in = FW'(value[7:0]) + FW'(value[15:8]) * FW'(W1)
                    + FW'(value[23:16]) * FW'(W2) + FW'(value[31:24]) * FW'(W3);
            prod    = (FW+SHIFT)'(fold_ff) * (FW+SHIFT)'(RECIP);
            quo_in  = prod[FW+SHIFT-1:SHIFT];
            rem_in  = RW'(held_ff - quo_ff * FW'(DIVISOR));
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               fold_vld_ff <= 1'b0;
               quo_vld_ff  <= 1'b0;
               done_ff     <= 1'b0;
            end else begin
               fold_vld_ff <= start;
               quo_vld_ff  <= fold_vld_ff;
               done_ff     <= quo_vld_ff;
            end
         end

         always_ff @(posedge clock) begin
            if (start) begin
               fold_ff <= fold_in;
            end
            if (fold_vld_ff) begin
               quo_ff  <= quo_in;
               held_ff <= fold_ff;
            end
            if (quo_vld_ff) begin
               rem_ff <= rem_in;
            end
         end

         assign done = done_ff;
         assign rem  = rem_ff;
      end
   endgenerate

endmodule

// ===== rtl/erst_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Echo tracker back end
// Owns the send-time ring, the sequence numbers and the counters, and
// produces one registered result word per work item.
// ----------------------------------------------------------------------------
module erst_back #(
   parameter int HISTORY_DEPTH = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               empty,
   input  erst_pkg::item_type head,
   output logic               pop,
   output logic               clearing,
   erst_rsp_if.source         rsp
);
   import erst_pkg::*;

   localparam int AW = $clog2(HISTORY_DEPTH);

   back_state_type     state_ff, state_in;
   logic [AW-1:0]      clr_idx_ff, clr_idx_in;
   logic [31:0]        next_send_ff, next_send_in;
   logic [AW-1:0]      send_idx_ff, send_idx_in;
   logic [31:0]        expected_ff, expected_in;
   logic signed [31:0] loss_ff, loss_in;
   logic [31:0]        late_ff, late_in;
   logic [31:0]        reply_ff, reply_in;
   logic [31:0]        dup_cnt_ff, dup_cnt_in;
   item_type           cur_ff, cur_in;
   logic [31:0]        rtt_ff, rtt_in;
   logic               dup_ff, dup_in;
   rsp_type            rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;

   slot_type           ring_mem [HISTORY_DEPTH];
   slot_type           rd_data_ff;
   logic               wr_en, rd_en;
   logic [AW-1:0]      wr_addr;
   slot_type           wr_data;

   logic               out_free;
   logic               load;
   logic               rem_start, rem_done;
   logic [AW-1:0]      rem_val;
   logic [31:0]        diff, gap, look_rtt;
   logic               in_win;
   logic signed [33:0] loss_sum;

   function automatic logic [31:0] sat_inc(input logic [31:0] v);
      return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
   endfunction

   erst_rem #(
      .DIVISOR (HISTORY_DEPTH)
   ) u_rem (
      .clock (clock),
      .reset (reset),
      .start (rem_start),
      .value (head.reply_seq),
      .done  (rem_done),
      .rem   (rem_val)
   );

   assign out_free = !rsp_valid_ff || rsp.ready;
   assign clearing = (state_ff == ST_CLEAR);
   assign pop      = (state_ff == ST_IDLE) && !empty && out_free;

   always_comb begin
      diff     = next_send_ff - head.reply_seq;
      in_win   = diff[31] || (diff < 32'(HISTORY_DEPTH));
      gap      = cur_ff.reply_seq - expected_ff;
      loss_sum = $signed({{2{loss_ff[31]}}, loss_ff}) + $signed({2'b00, gap});
      look_rtt = (cur_ff.now_time > rd_data_ff.stamp)
                 ? cur_ff.now_time - rd_data_ff.stamp : 32'd0;
   end

   always_comb begin
      state_in     = state_ff;
      clr_idx_in   = clr_idx_ff;
      next_send_in = next_send_ff;
      send_idx_in  = send_idx_ff;
      expected_in  = expected_ff;
      loss_in      = loss_ff;
      late_in      = late_ff;
      reply_in     = reply_ff;
      dup_cnt_in   = dup_cnt_ff;
      cur_in       = cur_ff;
      rtt_in       = rtt_ff;
      dup_in       = dup_ff;
      rsp_in       = rsp_ff;
      load         = 1'b0;
      rem_start    = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = send_idx_ff;
      wr_data      = '{seen: 1'b0, stamp: head.now_time};
      rd_en        = 1'b0;

      unique case (state_ff)
         ST_CLEAR: begin
            // sweep the ring to its reset contents
            wr_en   = 1'b1;
            wr_addr = clr_idx_ff;
            wr_data = '{seen: 1'b0, stamp: TIME_MAX};
            if (clr_idx_ff == AW'(HISTORY_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end else begin
               clr_idx_in = clr_idx_ff + AW'(1);
            end
         end
         ST_IDLE: begin
            if (pop) begin
               cur_in               = head;
               rsp_in.seq_out       = 32'd0;
               rsp_in.accepted      = 1'b0;
               rsp_in.is_dup        = 1'b0;
               rsp_in.rtt_valid     = 1'b0;
               rsp_in.rtt           = 32'd0;
               rsp_in.arrival_class = CLASS_NONE;
               rsp_in.loss_total    = loss_ff;
               rsp_in.late_total    = late_ff;
               rsp_in.reply_total   = reply_ff;
               rsp_in.dup_total     = dup_cnt_ff;
               unique case (head.kind)
                  KIND_SEND: begin
                     wr_en           = 1'b1;
                     rsp_in.seq_out  = next_send_ff;
                     rsp_in.accepted = 1'b1;
                     load            = 1'b1;
                     next_send_in    = next_send_ff + 32'd1;
                     // index tracks the sequence modulo the depth across wrap
                     if (next_send_ff == SEQ_MAX ||
                         send_idx_ff == AW'(HISTORY_DEPTH - 1)) begin
                        send_idx_in = '0;
                     end else begin
                        send_idx_in = send_idx_ff + AW'(1);
                     end
                  end
                  KIND_RESTART: begin
                     rsp_in.accepted = 1'b1;
                     load            = 1'b1;
                     next_send_in    = 32'd0;
                     send_idx_in     = '0;
                     expected_in     = 32'd0;
                  end
                  KIND_FOREIGN: begin
                     rsp_in.seq_out = head.reply_seq;
                     load           = 1'b1;
                  end
                  KIND_REPLY: begin
                     rtt_in = 32'd0;
                     dup_in = 1'b0;
                     if (in_win) begin
                        rem_start = 1'b1;
                        state_in  = ST_REM;
                     end else begin
                        state_in  = ST_FINISH;
                     end
                  end
                  default: begin
                     load = 1'b1;
                  end
               endcase
            end
         end
         ST_REM: begin
            if (rem_done) begin
               rd_en    = 1'b1;
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            rtt_in   = look_rtt;
            dup_in   = rd_data_ff.seen;
            wr_en    = 1'b1;
            wr_addr  = rem_val;
            wr_data  = '{seen: 1'b1, stamp: rd_data_ff.stamp};
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) begin
               load     = 1'b1;
               state_in = ST_IDLE;
               if (dup_ff) begin
                  dup_cnt_in = sat_inc(dup_cnt_ff);
               end else begin
                  reply_in = sat_inc(reply_ff);
               end
               if (cur_ff.reply_seq == expected_ff) begin
                  rsp_in.arrival_class = CLASS_IN_ORDER;
                  expected_in          = expected_ff + 32'd1;
               end else if (cur_ff.reply_seq > expected_ff) begin
                  rsp_in.arrival_class = CLASS_JUMP;
                  expected_in          = cur_ff.reply_seq + 32'd1;
                  if (loss_sum > 34'sh0_7FFF_FFFF) begin
                     loss_in = 32'sh7FFF_FFFF;
                  end else begin
                     loss_in = loss_sum[31:0];
                  end
               end else begin
                  rsp_in.arrival_class = CLASS_LATE;
                  late_in              = sat_inc(late_ff);
                  if (!dup_ff && rtt_ff != 32'd0 && loss_ff != 32'sh8000_0000) begin
                     loss_in = loss_ff - 32'sd1;
                  end
               end
               rsp_in.seq_out     = cur_ff.reply_seq;
               rsp_in.accepted    = 1'b1;
               rsp_in.is_dup      = dup_ff;
               rsp_in.rtt_valid   = (rtt_ff != 32'd0) && !dup_ff;
               rsp_in.rtt         = rtt_ff;
               rsp_in.loss_total  = loss_in;
               rsp_in.late_total  = late_in;
               rsp_in.reply_total = reply_in;
               rsp_in.dup_total   = dup_cnt_in;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase

      rsp_valid_in = load || (rsp_valid_ff && !rsp.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_idx_ff   <= '0;
         next_send_ff <= 32'd0;
         send_idx_ff  <= '0;
         expected_ff  <= 32'd0;
         loss_ff      <= 32'sd0;
         late_ff      <= 32'd0;
         reply_ff     <= 32'd0;
         dup_cnt_ff   <= 32'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_idx_ff   <= clr_idx_in;
         next_send_ff <= next_send_in;
         send_idx_ff  <= send_idx_in;
         expected_ff  <= expected_in;
         loss_ff      <= loss_in;
         late_ff      <= late_in;
         reply_ff     <= reply_in;
         dup_cnt_ff   <= dup_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      rtt_ff <= rtt_in;
      dup_ff <= dup_in;
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ring_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= ring_mem[rem_val];
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.seq_out       = rsp_ff.seq_out;
   assign rsp.accepted      = rsp_ff.accepted;
   assign rsp.is_dup        = rsp_ff.is_dup;
   assign rsp.rtt_valid     = rsp_ff.rtt_valid;
   assign rsp.rtt           = rsp_ff.rtt;
   assign rsp.arrival_class = rsp_ff.arrival_class;
   assign rsp.loss_total    = rsp_ff.loss_total;
   assign rsp.late_total    = rsp_ff.late_total;
   assign rsp.reply_total   = rsp_ff.reply_total;
   assign rsp.dup_total     = rsp_ff.dup_total;

   a_rem_done_in_rem: assert property (@(posedge clock) disable iff (reset)
      rem_done |-> state_ff == ST_REM)
      else $error("slot index finished outside its wait state");

   a_look_to_finish: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_LOOK |=> state_ff == ST_FINISH)
      else $error("ring lookup not followed by finish");

   a_rtt_valid_rule: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.rtt_valid |-> rsp_ff.rtt != 32'd0 && !rsp_ff.is_dup)
      else $error("rtt marked valid on zero or duplicate");

   a_reject_class: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.accepted |-> rsp_ff.arrival_class == CLASS_NONE)
      else $error("rejected word carries an arrival class");

endmodule

// ===== rtl/echo_reply_sequence_tracker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Echo reply sequence tracker
// Tracks echo request send times and classifies replies for loss, late
// arrival, duplicates and round-trip time.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake           Carries
//  req_if    in         valid/ready         req_type, now_time, reply_id, reply_seq
//  rsp_if    out        valid/ready         seq_out .. dup_total, one per input word
//  csr       in/out     APB, pready tied 1  my_id at byte address 0
//
//  Send, restart, foreign and unused words finish in the idle state of the back
//  end. A matching reply outside the window goes from idle to finish; inside it
//  waits for the slot index unit (a mask when HISTORY_DEPTH is a power of two,
//  else a fold and a divide), then reads the ring, then finishes. The back end
//  handles one word at a time. After reset every ring slot is swept; req_if.ready
//  stays low until the sweep is done. A two-word queue lets input words be taken
//  while a result waits in the output register for rsp_if.ready.
// ----------------------------------------------------------------------------
module echo_reply_sequence_tracker #(
   parameter int HISTORY_DEPTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   erst_req_if.sink    req_if,
   erst_rsp_if.source  rsp_if,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [1:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import erst_pkg::*;

   logic [15:0] my_id_ff, my_id_in;
   logic        csr_write;
   logic        push, pop, full, empty, clearing;
   item_type    push_item, head;

   // Configuration register: write in the access phase, low 16 bits kept and read back
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign prdata    = (paddr == CSR_MY_ID_ADDR) ? {16'd0, my_id_ff} : 32'd0;

   always_comb begin
      my_id_in = my_id_ff;
      if (csr_write && paddr == CSR_MY_ID_ADDR) begin
         my_id_in = pwdata[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         my_id_ff <= 16'd0;
      end else begin
         my_id_ff <= my_id_in;
      end
   end

   // Front: classify each word against my_id, hold off during the sweep
   erst_front u_front (
      .req       (req_if),
      .my_id     (my_id_ff),
      .fifo_full (full),
      .clearing  (clearing),
      .push      (push),
      .push_item (push_item)
   );

   // Queue: decouple acceptance from the ring and counter work
   erst_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (full),
      .pop       (pop),
      .empty     (empty),
      .head      (head)
   );

   // Back: ring lookups, sequence tracking, counters and the result register
   erst_back #(
      .HISTORY_DEPTH (HISTORY_DEPTH)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .empty    (empty),
      .head     (head),
      .pop      (pop),
      .clearing (clearing),
      .rsp      (rsp_if)
   );

endmodule
